@@ rtl/core/tee_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tee_pkg
// Shared types and constants of the harmonic/EWMA throughput estimator.
// ----------------------------------------------------------------------------
package tee_pkg;

  localparam int HIST_DEPTH = 24;
  localparam int IDX_W      = $clog2(HIST_DEPTH);
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

  localparam int RATE_W = 40;
  localparam int WGT_W  = 16;
  localparam int SPAN_W = 5;
  localparam int TTFB_W = 32;
  localparam int TIME_W = 48;
  localparam int BYTE_W = 32;
  localparam int BPS_W  = 36;
  localparam int DIV_W  = 64;
  localparam int US_W   = 28;
  localparam int PROD_W = BYTE_W + US_W;

  localparam int S_DATA_W = 208;
  localparam int M_DATA_W = 112;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;

  localparam logic [RATE_W-1:0] RATE_MAX = '1;
  localparam logic [US_W-1:0]   US_Q8    = 28'd256000000;

  // operation codes
  localparam logic [1:0] OP_DONE    = 2'd0;
  localparam logic [1:0] OP_PROG    = 2'd1;
  localparam logic [1:0] OP_CLR_EST = 2'd2;
  localparam logic [1:0] OP_CLR_ALL = 2'd3;

  // mix unit operand select
  localparam logic [1:0] MIX_FAST   = 2'd0;
  localparam logic [1:0] MIX_SLOW   = 2'd1;
  localparam logic [1:0] MIX_FLIGHT = 2'd2;
  localparam logic [1:0] MIX_BLEND  = 2'd3;

  // divider operand select
  localparam logic [1:0] DIV_RATE  = 2'd0;
  localparam logic [1:0] DIV_RECIP = 2'd1;
  localparam logic [1:0] DIV_HARM  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_FAST_W  = 3'd0;
  localparam logic [2:0] REG_SLOW_W  = 3'd1;
  localparam logic [2:0] REG_PROG_W  = 3'd2;
  localparam logic [2:0] REG_SPAN    = 3'd3;
  localparam logic [2:0] REG_BLEND_W = 3'd4;

  typedef struct packed {
    logic [WGT_W-1:0]  fast_w;
    logic [WGT_W-1:0]  slow_w;
    logic [WGT_W-1:0]  prog_w;
    logic [SPAN_W-1:0] span;
    logic [WGT_W-1:0]  blend_w;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             prog_chk;
    logic             mul;
    logic             div_start;
    logic [1:0]       div_sel;
    logic             sat;
    logic             ring_wr;
    logic             mix_a;
    logic             mix_b;
    logic             wr_mix;
    logic [1:0]       mix_sel;
    logic [IDX_W-1:0] rd_addr;
    logic             med_cap;
    logic             med_cmp;
    logic             med_eval;
    logic             med_done;
    logic             med_zero;
    logic             har_init;
    logic             har_dec;
    logic             har_acc;
    logic             har_set;
    logic             har_zero;
    logic             clr_est;
    logic             clr_all;
    logic             finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] span;
    logic             upd;
    logic             rate_nz;
    logic             cnt_nz;
    logic             m_nz;
    logic             h_nz;
    logic             div_done;
  } sts_t;

endpackage

@@ rtl/core/tee_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tee_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tee_div import tee_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [DIV_W-1:0] quo
);

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  numr;
  logic [DIV_W-1:0]  denr;
  logic [DIV_W:0]    rem_sh;
  logic              ge;

  assign rem_sh = {rem, numr[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, denr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= '0;
      end else if (busy) begin
        steps <= steps + 1'b1;
        if (steps == STEP_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      numr <= num;
      denr <= den;
      quo  <= '0;
    end else if (busy) begin
      rem  <= ge ? DIV_W'(rem_sh - {1'b0, denr}) : rem_sh[DIV_W-1:0];
      numr <= {numr[DIV_W-2:0], 1'b0};
      quo  <= {quo[DIV_W-2:0], ge};
    end
  end

endmodule

@@ rtl/core/tee_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tee_dp
// Estimator datapath: sample history, averages, median and progress context.
// ----------------------------------------------------------------------------
module tee_dp import tee_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  cfg_t              cfg,
  input  logic [1:0]        in_op,
  input  logic [TTFB_W-1:0] in_ttfb,
  input  logic [TTFB_W-1:0] in_total,
  input  logic [BYTE_W-1:0] in_size,
  input  logic [TIME_W-1:0] in_now,
  input  logic [BYTE_W-1:0] in_exp,
  input  logic [BYTE_W-1:0] in_recv,
  output sts_t              sts,
  output logic [RATE_W-1:0] res_tput,
  output logic [TTFB_W-1:0] res_median
);

  // latched item
  logic [1:0]        op;
  logic [TTFB_W-1:0] ttfb;
  logic [TTFB_W-1:0] total;
  logic [BYTE_W-1:0] size;
  logic [TIME_W-1:0] now;
  logic [BYTE_W-1:0] expb;
  logic [BYTE_W-1:0] recv;

  // history
  logic [RATE_W-1:0] rate_mem [HIST_DEPTH];
  logic [TTFB_W-1:0] ttfb_mem [HIST_DEPTH];
  logic [RATE_W-1:0] rate_rdata;
  logic [TTFB_W-1:0] ttfb_rdata;
  logic [CNT_W-1:0]  fill_count;
  logic [IDX_W-1:0]  write_slot;
  logic [IDX_W-1:0]  hptr;

  // estimates
  logic [RATE_W-1:0] fast_avg;
  logic [RATE_W-1:0] slow_avg;
  logic [RATE_W-1:0] harmonic_avg;
  logic [TTFB_W-1:0] ttfb_median;
  logic [RATE_W-1:0] rate;

  // progress context
  logic              progress_valid;
  logic              progress_has_rate;
  logic [RATE_W-1:0] progress_rate;
  logic [RATE_W-1:0] flight_rate;
  logic [TIME_W-1:0] last_report_us;
  logic [BYTE_W-1:0] last_received;
  logic [BYTE_W-1:0] last_expected;
  logic [TIME_W-1:0] base_time_us;
  logic [BYTE_W-1:0] base_received;
  logic              upd;
  logic [BYTE_W-1:0] dbytes;
  logic [TIME_W-1:0] dus;

  // arithmetic
  logic [PROD_W-1:0]   prod;
  logic [RATE_W+15:0]  p1;
  logic [RATE_W+16:0]  mix_sum;
  logic [RATE_W-1:0]   mixres;
  logic [DIV_W-1:0]    harm_sum;
  logic [CNT_W-1:0]    harm_cnt;

  // median search
  logic [TTFB_W-1:0] cand;
  logic [CNT_W-1:0]  lt_cnt;
  logic [CNT_W-1:0]  le_cnt;
  logic [TTFB_W-1:0] med_lo;
  logic [TTFB_W-1:0] med_hi;

  logic [DIV_W-1:0] div_num;
  logic [DIV_W-1:0] div_den;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  logic [RATE_W-1:0] quo_sat;

  logic [WGT_W-1:0]  mix_w;
  logic [WGT_W:0]    mix_wc;
  logic [RATE_W-1:0] mix_fresh;
  logic [RATE_W-1:0] mix_old;
  logic [RATE_W-1:0] m_val;
  logic [RATE_W-1:0] mix_tgt_old;
  logic [RATE_W-1:0] flight_new;
  logic [TTFB_W-1:0] dl_time;
  logic              restart;
  logic [TIME_W-1:0] base_t_n;
  logic [BYTE_W-1:0] base_r_n;
  logic [CNT_W-1:0]  k_lo;
  logic [CNT_W-1:0]  k_hi;
  logic [CNT_W-1:0]  span_cfg;
  logic [RATE_W-1:0] t_base;
  logic [TTFB_W:0]   med_add;

  assign dl_time = (total > ttfb) ? TTFB_W'(total - ttfb) : TTFB_W'(1);

  always_comb begin
    div_num = '0;
    div_den = '0;
    case (cmd.div_sel)
      DIV_RATE: begin
        div_num = DIV_W'(prod);
        div_den = (op == OP_DONE) ? DIV_W'(dl_time) : DIV_W'(dus);
      end
      DIV_RECIP: begin
        div_num = DIV_W'(1) << 56;
        div_den = DIV_W'(rate_rdata);
      end
      DIV_HARM: begin
        div_num = DIV_W'(harm_cnt) << 56;
        div_den = harm_sum;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  tee_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign quo_sat = (div_quo > DIV_W'(RATE_MAX)) ? RATE_MAX : div_quo[RATE_W-1:0];

  // smaller average when both exist, else whichever exists
  always_comb begin
    if (fast_avg != '0 && slow_avg != '0) begin
      m_val = (fast_avg < slow_avg) ? fast_avg : slow_avg;
    end else begin
      m_val = (fast_avg > slow_avg) ? fast_avg : slow_avg;
    end
  end

  always_comb begin
    case (cmd.mix_sel)
      MIX_FAST: begin
        mix_w = cfg.fast_w; mix_fresh = rate; mix_old = fast_avg;
      end
      MIX_SLOW: begin
        mix_w = cfg.slow_w; mix_fresh = rate; mix_old = slow_avg;
      end
      MIX_FLIGHT: begin
        mix_w = cfg.prog_w; mix_fresh = rate; mix_old = flight_rate;
      end
      MIX_BLEND: begin
        mix_w = cfg.blend_w; mix_fresh = harmonic_avg; mix_old = m_val;
      end
      default: begin
        mix_w = cfg.fast_w; mix_fresh = rate; mix_old = fast_avg;
      end
    endcase
  end

  assign mix_wc      = 17'h10000 - {1'b0, mix_w};
  assign mix_sum     = {1'b0, p1} + (mix_wc * mix_old);
  assign mix_tgt_old = mix_old;
  assign flight_new  = (flight_rate != '0) ? mixres : rate;

  // progress restart test
  assign restart = !progress_valid || (now < last_report_us) || (recv < last_received) ||
                   (expb != '0 && expb != last_expected && recv == '0);
  assign base_t_n = restart ? now : base_time_us;
  assign base_r_n = restart ? '0 : base_received;

  assign k_lo     = CNT_W'(fill_count - 1'b1) >> 1;
  assign k_hi     = fill_count >> 1;
  assign span_cfg = (CNT_W'(cfg.span) < fill_count) ? CNT_W'(cfg.span) : fill_count;
  assign med_add  = {1'b0, med_lo} + {1'b0, med_hi};

  // history memories
  always_ff @(posedge clk) begin
    if (cmd.ring_wr) begin
      rate_mem[write_slot] <= rate;
      ttfb_mem[write_slot] <= ttfb;
    end
    rate_rdata <= rate_mem[hptr];
    ttfb_rdata <= ttfb_mem[cmd.rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= in_op;
      ttfb  <= in_ttfb;
      total <= in_total;
      size  <= in_size;
      now   <= in_now;
      expb  <= in_exp;
      recv  <= in_recv;
    end
    if (cmd.mul) begin
      prod <= ((op == OP_DONE) ? size : dbytes) * US_Q8;
    end
    if (cmd.sat) begin
      rate <= quo_sat;
    end
    if (cmd.mix_a) begin
      p1 <= mix_w * mix_fresh;
    end
    if (cmd.mix_b) begin
      mixres <= mix_sum[RATE_W+15:16];
    end
    if (cmd.med_cap) begin
      cand   <= ttfb_rdata;
      lt_cnt <= '0;
      le_cnt <= '0;
    end
    if (cmd.med_cmp) begin
      if (ttfb_rdata < cand) begin
        lt_cnt <= lt_cnt + 1'b1;
      end
      if (ttfb_rdata <= cand) begin
        le_cnt <= le_cnt + 1'b1;
      end
    end
    if (cmd.med_eval) begin
      if (lt_cnt <= k_lo && k_lo < le_cnt) begin
        med_lo <= cand;
      end
      if (lt_cnt <= k_hi && k_hi < le_cnt) begin
        med_hi <= cand;
      end
    end
    if (cmd.prog_chk) begin
      upd    <= (recv > base_r_n) && (now > base_t_n);
      dbytes <= recv - base_r_n;
      dus    <= now - base_t_n;
    end
  end

  // estimator state
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_all) begin
      fill_count        <= '0;
      write_slot        <= '0;
      hptr              <= '0;
      fast_avg          <= '0;
      slow_avg          <= '0;
      harmonic_avg      <= '0;
      ttfb_median       <= '0;
      harm_sum          <= '0;
      harm_cnt          <= '0;
      progress_valid    <= 1'b0;
      progress_has_rate <= 1'b0;
      progress_rate     <= '0;
      flight_rate       <= '0;
      last_report_us    <= '0;
      last_received     <= '0;
      last_expected     <= '0;
      base_time_us      <= '0;
      base_received     <= '0;
    end else begin
      if (cmd.clr_est) begin
        fast_avg          <= '0;
        slow_avg          <= '0;
        harmonic_avg      <= '0;
        progress_has_rate <= 1'b0;
        progress_rate     <= '0;
      end
      if (cmd.ring_wr) begin
        write_slot <= (write_slot == IDX_W'(HIST_DEPTH - 1)) ? '0 : write_slot + 1'b1;
        if (fill_count < CNT_W'(HIST_DEPTH)) begin
          fill_count <= fill_count + 1'b1;
        end
      end
      if (cmd.wr_mix) begin
        case (cmd.mix_sel)
          MIX_FAST: fast_avg <= (mix_tgt_old != '0) ? mixres : rate;
          MIX_SLOW: slow_avg <= (mix_tgt_old != '0) ? mixres : rate;
          MIX_FLIGHT: begin
            flight_rate       <= flight_new;
            progress_rate     <= flight_new;
            progress_has_rate <= flight_new != '0;
            base_time_us      <= now;
            base_received     <= recv;
          end
          default: begin
          end
        endcase
      end
      if (cmd.prog_chk) begin
        if (restart) begin
          flight_rate   <= '0;
          base_received <= '0;
          base_time_us  <= now;
          if (progress_valid) begin
            progress_rate     <= '0;
            progress_has_rate <= 1'b0;
          end
        end
        progress_valid <= 1'b1;
        last_report_us <= now;
        last_received  <= recv;
        last_expected  <= expb;
      end
      if (cmd.med_zero) begin
        ttfb_median <= '0;
      end
      if (cmd.med_done) begin
        ttfb_median <= med_add[TTFB_W:1];
      end
      if (cmd.har_init) begin
        hptr     <= (write_slot == '0) ? IDX_W'(HIST_DEPTH - 1) : write_slot - 1'b1;
        harm_sum <= '0;
        harm_cnt <= '0;
      end
      if (cmd.har_dec) begin
        hptr <= (hptr == '0) ? IDX_W'(HIST_DEPTH - 1) : hptr - 1'b1;
      end
      if (cmd.har_acc) begin
        harm_sum <= harm_sum + div_quo;
        harm_cnt <= harm_cnt + 1'b1;
      end
      if (cmd.har_set) begin
        harmonic_avg <= quo_sat;
      end
      if (cmd.har_zero) begin
        harmonic_avg <= '0;
      end
    end
  end

  // blend, capped by the in-flight rate
  always_comb begin
    if (m_val != '0 && harmonic_avg != '0) begin
      t_base = mixres;
    end else if (m_val != '0) begin
      t_base = m_val;
    end else begin
      t_base = harmonic_avg;
    end
    res_tput = t_base;
    if (progress_has_rate) begin
      res_tput = (t_base != '0 && t_base < progress_rate) ? t_base : progress_rate;
    end
  end

  assign res_median = ttfb_median;

  always_comb begin
    sts.op       = op;
    sts.fill     = fill_count;
    sts.span     = span_cfg;
    sts.upd      = upd;
    sts.rate_nz  = rate_rdata != '0;
    sts.cnt_nz   = harm_cnt != '0;
    sts.m_nz     = m_val != '0;
    sts.h_nz     = harmonic_avg != '0;
    sts.div_done = div_done;
  end

endmodule

@@ rtl/core/tee_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tee_ctrl
// Sequencer that steps the datapath through one item.
// ----------------------------------------------------------------------------
module tee_ctrl import tee_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic out_busy,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISPATCH = 5'd1;
  localparam logic [4:0] S_PCHK     = 5'd2;
  localparam logic [4:0] S_PCHK2    = 5'd3;
  localparam logic [4:0] S_MUL      = 5'd4;
  localparam logic [4:0] S_DIVGO    = 5'd5;
  localparam logic [4:0] S_DIVW     = 5'd6;
  localparam logic [4:0] S_SAT      = 5'd7;
  localparam logic [4:0] S_RING     = 5'd8;
  localparam logic [4:0] S_MIXA     = 5'd9;
  localparam logic [4:0] S_MIXB     = 5'd10;
  localparam logic [4:0] S_MIXW     = 5'd11;
  localparam logic [4:0] S_MED_ST   = 5'd12;
  localparam logic [4:0] S_MED_RDC  = 5'd13;
  localparam logic [4:0] S_MED_CAP  = 5'd14;
  localparam logic [4:0] S_MED_RDJ  = 5'd15;
  localparam logic [4:0] S_MED_CMP  = 5'd16;
  localparam logic [4:0] S_MED_EVAL = 5'd17;
  localparam logic [4:0] S_MED_DONE = 5'd18;
  localparam logic [4:0] S_HAR_ST   = 5'd19;
  localparam logic [4:0] S_HAR_RD   = 5'd20;
  localparam logic [4:0] S_HAR_CHK  = 5'd21;
  localparam logic [4:0] S_HAR_DW   = 5'd22;
  localparam logic [4:0] S_HAR_NEXT = 5'd23;
  localparam logic [4:0] S_HAR_FIN  = 5'd24;
  localparam logic [4:0] S_HAR_FW   = 5'd25;
  localparam logic [4:0] S_BLEND    = 5'd26;
  localparam logic [4:0] S_FIN      = 5'd27;

  logic [4:0]       state;
  logic [4:0]       state_next;
  logic [1:0]       mtgt;
  logic [1:0]       mtgt_next;
  logic [CNT_W-1:0] ci;
  logic [CNT_W-1:0] ci_next;
  logic [CNT_W-1:0] cj;
  logic [CNT_W-1:0] cj_next;
  logic [CNT_W-1:0] ci_inc;
  logic [CNT_W-1:0] cj_inc;

  assign in_ready = (state == S_IDLE);
  assign ci_inc   = ci + 1'b1;
  assign cj_inc   = cj + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mtgt  <= MIX_FAST;
      ci    <= '0;
      cj    <= '0;
    end else begin
      state <= state_next;
      mtgt  <= mtgt_next;
      ci    <= ci_next;
      cj    <= cj_next;
    end
  end

  always_comb begin
    state_next = state;
    mtgt_next  = mtgt;
    ci_next    = ci;
    cj_next    = cj;
    cmd        = '0;
    cmd.mix_sel = mtgt;
    cmd.rd_addr = ci[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_DONE: state_next = S_MUL;
          OP_PROG: state_next = S_PCHK;
          OP_CLR_EST: begin
            cmd.clr_est = 1'b1;
            state_next  = S_BLEND;
          end
          default: begin
            cmd.clr_all = 1'b1;
            state_next  = S_BLEND;
          end
        endcase
      end
      S_PCHK: begin
        cmd.prog_chk = 1'b1;
        state_next   = S_PCHK2;
      end
      S_PCHK2: begin
        state_next = sts.upd ? S_MUL : S_BLEND;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIVGO;
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RATE;
        state_next    = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          state_next = S_SAT;
        end
      end
      S_SAT: begin
        cmd.sat = 1'b1;
        if (sts.op == OP_DONE) begin
          state_next = S_RING;
        end else begin
          mtgt_next  = MIX_FLIGHT;
          state_next = S_MIXA;
        end
      end
      S_RING: begin
        cmd.ring_wr = 1'b1;
        mtgt_next   = MIX_FAST;
        state_next  = S_MIXA;
      end
      S_MIXA: begin
        cmd.mix_a  = 1'b1;
        state_next = S_MIXB;
      end
      S_MIXB: begin
        cmd.mix_b  = 1'b1;
        state_next = S_MIXW;
      end
      S_MIXW: begin
        cmd.wr_mix = 1'b1;
        case (mtgt)
          MIX_FAST: begin
            mtgt_next  = MIX_SLOW;
            state_next = S_MIXA;
          end
          MIX_SLOW:   state_next = S_MED_ST;
          MIX_FLIGHT: state_next = S_BLEND;
          default:    state_next = S_FIN;
        endcase
      end
      S_MED_ST: begin
        ci_next = '0;
        if (sts.fill == '0) begin
          cmd.med_zero = 1'b1;
          state_next   = S_HAR_ST;
        end else begin
          state_next = S_MED_RDC;
        end
      end
      S_MED_RDC: begin
        state_next = S_MED_CAP;
      end
      S_MED_CAP: begin
        cmd.med_cap = 1'b1;
        cj_next     = '0;
        state_next  = S_MED_RDJ;
      end
      S_MED_RDJ: begin
        cmd.rd_addr = cj[IDX_W-1:0];
        state_next  = S_MED_CMP;
      end
      S_MED_CMP: begin
        cmd.med_cmp = 1'b1;
        cj_next     = cj_inc;
        state_next  = (cj_inc == sts.fill) ? S_MED_EVAL : S_MED_RDJ;
      end
      S_MED_EVAL: begin
        cmd.med_eval = 1'b1;
        ci_next      = ci_inc;
        state_next   = (ci_inc == sts.fill) ? S_MED_DONE : S_MED_RDC;
      end
      S_MED_DONE: begin
        cmd.med_done = 1'b1;
        state_next   = S_HAR_ST;
      end
      S_HAR_ST: begin
        cmd.har_init = 1'b1;
        ci_next      = '0;
        state_next   = (sts.span == '0) ? S_HAR_FIN : S_HAR_RD;
      end
      S_HAR_RD: begin
        state_next = S_HAR_CHK;
      end
      S_HAR_CHK: begin
        if (sts.rate_nz) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_RECIP;
          state_next    = S_HAR_DW;
        end else begin
          state_next = S_HAR_NEXT;
        end
      end
      S_HAR_DW: begin
        if (sts.div_done) begin
          cmd.har_acc = 1'b1;
          state_next  = S_HAR_NEXT;
        end
      end
      S_HAR_NEXT: begin
        cmd.har_dec = 1'b1;
        ci_next     = ci_inc;
        state_next  = (ci_inc == sts.span) ? S_HAR_FIN : S_HAR_RD;
      end
      S_HAR_FIN: begin
        if (sts.cnt_nz) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_HARM;
          state_next    = S_HAR_FW;
        end else begin
          cmd.har_zero = 1'b1;
          state_next   = S_BLEND;
        end
      end
      S_HAR_FW: begin
        if (sts.div_done) begin
          cmd.har_set = 1'b1;
          state_next  = S_BLEND;
        end
      end
      S_BLEND: begin
        if (sts.m_nz && sts.h_nz) begin
          mtgt_next  = MIX_BLEND;
          state_next = S_MIXA;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        // hold here while the previous result beat is still waiting
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/throughput_estimator_ewma_harmonic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// throughput_estimator_ewma_harmonic
// Download throughput estimator blending a harmonic mean with fast/slow EWMAs.
// ----------------------------------------------------------------------------
// Takes one report beat at a time and answers each with one result beat.
// A finished download runs the rate division, the median selection over the
// n stored entries of a history of up to 24, one reciprocal division per
// nonzero rate in a harmonic window of up to 24 entries, and a final division
// when any of those rates was nonzero. The single bit-per-cycle divider and
// the one-read-port history memory set the length of these steps. A progress
// report runs the rate division only when it updates the in-flight rate; the
// two clear operations go straight to the blend. The result beat waits in an
// output register, so the next report can be taken while it is pending; only
// the last step of the next item stalls until that beat is taken.
// Configuration registers are at byte addresses 0, 4, 8, 12 and 16; the user
// must write them only while the block is idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module throughput_estimator_ewma_harmonic import tee_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // ttfb_us, total_time_us, size_bytes, now_us, expected_bytes, received_bytes
  input  logic [S_DATA_W-1:0] s_tdata,
  // operation
  input  logic [1:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // throughput, bandwidth_bps, median_ttfb_us, zero fill
  output logic [M_DATA_W-1:0] m_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  cfg_t              cfg;
  cmd_t              cmd;
  sts_t              sts;
  logic [RATE_W-1:0] res_tput;
  logic [TTFB_W-1:0] res_median;
  logic [BPS_W-1:0]  bps;
  logic              cfg_wr;
  logic [2:0]        reg_idx;
  logic              out_hold;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // result beat still waiting after this edge
  assign out_hold = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_w  <= 16'd32768;
      cfg.slow_w  <= 16'd6554;
      cfg.prog_w  <= 16'd19661;
      cfg.span    <= 5'd8;
      cfg.blend_w <= 16'd39322;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FAST_W:  cfg.fast_w  <= pwdata[WGT_W-1:0];
        REG_SLOW_W:  cfg.slow_w  <= pwdata[WGT_W-1:0];
        REG_PROG_W:  cfg.prog_w  <= pwdata[WGT_W-1:0];
        REG_SPAN:    cfg.span    <= pwdata[SPAN_W-1:0];
        REG_BLEND_W: cfg.blend_w <= pwdata[WGT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FAST_W:  prdata = APB_DW'(cfg.fast_w);
      REG_SLOW_W:  prdata = APB_DW'(cfg.slow_w);
      REG_PROG_W:  prdata = APB_DW'(cfg.prog_w);
      REG_SPAN:    prdata = APB_DW'(cfg.span);
      REG_BLEND_W: prdata = APB_DW'(cfg.blend_w);
      default:     prdata = '0;
    endcase
  end

  tee_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_busy (out_hold),
    .sts      (sts),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  tee_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .in_op      (s_tuser),
    .in_ttfb    (s_tdata[31:0]),
    .in_total   (s_tdata[63:32]),
    .in_size    (s_tdata[95:64]),
    .in_now     (s_tdata[143:96]),
    .in_exp     (s_tdata[175:144]),
    .in_recv    (s_tdata[207:176]),
    .sts        (sts),
    .res_tput   (res_tput),
    .res_median (res_median)
  );

  // bits per second is the Q32.8 byte rate times 8
  assign bps = (res_tput != '0) ? BPS_W'(res_tput[RATE_W-1:5]) : '1;

  // output register holds the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {4'b0, res_median, bps, res_tput};
    end
  end

  a_finish_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !out_hold)
    else $error("result beat overwritten while still pending");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after an accepted beat");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("pending result beat changed or dropped");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result beat without an item in progress");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the harmonic/EWMA throughput estimator.
// ----------------------------------------------------------------------------
// Reports are driven on the input stream and scored against a predictor of the
// block that is kept in this module. The run starts with directed reports,
// then goes through three random phases. Each phase uses its own register
// settings and its own pattern of idle cycles on the two streams. Every
// result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import tee_pkg::*;

  typedef struct packed {
    logic [RATE_W-1:0] thr;
    logic [BPS_W-1:0]  bps;
    logic [TTFB_W-1:0] med;
  } estimate_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic [1:0]          s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic                psel, penable, pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  throughput_estimator_ewma_harmonic DUT (.*);

  // predictor state
  logic [WGT_W-1:0]  w_fast, w_slow, w_prog, w_blend;
  logic [SPAN_W-1:0] hspan;
  logic [63:0]       rate_hist [HIST_DEPTH];
  logic [31:0]       ttfb_hist [HIST_DEPTH];
  int                n_fill, wr_slot;
  logic [63:0]       fast_ewma, slow_ewma, harm_mean, prog_rate, flight_ewma;
  logic [31:0]       med_ttfb;
  logic              prog_valid, prog_has;
  logic [63:0]       last_now, base_now;
  logic [31:0]       last_recv, last_exp, base_recv;

  estimate_t estimates_due[$];
  int        errors = 0;
  int        src_idle_pct = 0;
  int        snk_idle_pct = 0;

  // sender-side progress context for well-formed report sequences
  logic [47:0] flow_now;
  logic [31:0] flow_recv, flow_exp;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #250_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [63:0] wmix(logic [WGT_W-1:0] w, logic [63:0] fresh,
                                       logic [63:0] old);
    return (64'(w) * fresh + (64'd65536 - 64'(w)) * old) >> 16;
  endfunction

  function automatic logic [63:0] byte_rate(logic [63:0] bytes, logic [63:0] us);
    logic [63:0] r;
    r = (bytes * 64'd256000000) / us;
    return (r > 64'(RATE_MAX)) ? 64'(RATE_MAX) : r;
  endfunction

  function automatic void clear_estimator();
    for (int i = 0; i < HIST_DEPTH; i++) begin
      rate_hist[i] = 0;
      ttfb_hist[i] = 0;
    end
    n_fill = 0; wr_slot = 0;
    fast_ewma = 0; slow_ewma = 0; harm_mean = 0; med_ttfb = 0;
    prog_valid = 0; prog_has = 0; prog_rate = 0; flight_ewma = 0;
    last_now = 0; base_now = 0; last_recv = 0; last_exp = 0; base_recv = 0;
  endfunction

  function automatic void refresh_history_stats();
    logic [31:0] srt [HIST_DEPTH];
    logic [31:0] v;
    logic [63:0] sum, h;
    int j, span, cnt, slot;
    sum = 0; cnt = 0;
    for (int i = 0; i < n_fill; i++) begin
      v = ttfb_hist[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    if (n_fill == 0) med_ttfb = 0;
    else if (n_fill % 2) med_ttfb = srt[n_fill/2];
    else med_ttfb = 32'((64'(srt[n_fill/2-1]) + 64'(srt[n_fill/2])) >> 1);
    span = (int'(hspan) < n_fill) ? int'(hspan) : n_fill;
    for (int i = 0; i < span; i++) begin
      slot = (wr_slot + HIST_DEPTH - 1 - i) % HIST_DEPTH;
      if (rate_hist[slot] > 0) begin
        sum += (64'd1 << 56) / rate_hist[slot];
        cnt++;
      end
    end
    if (cnt > 0 && sum > 0) begin
      h = (64'(cnt) << 56) / sum;
      harm_mean = (h > 64'(RATE_MAX)) ? 64'(RATE_MAX) : h;
    end else begin
      harm_mean = 0;
    end
  endfunction

  function automatic estimate_t predict_estimate(logic [1:0] op, logic [S_DATA_W-1:0] d);
    logic [31:0] ttfb, total, size, xp, rv;
    logic [63:0] now, dur, r, m, t;
    estimate_t e;
    ttfb = d[31:0]; total = d[63:32]; size = d[95:64];
    now = 64'(d[143:96]); xp = d[175:144]; rv = d[207:176];
    case (op)
      OP_DONE: begin
        dur = (total > ttfb) ? 64'(total - ttfb) : 64'd1;
        r = byte_rate(64'(size), dur);
        rate_hist[wr_slot] = r;
        ttfb_hist[wr_slot] = ttfb;
        wr_slot = (wr_slot + 1) % HIST_DEPTH;
        if (n_fill < HIST_DEPTH) n_fill++;
        fast_ewma = (fast_ewma > 0) ? wmix(w_fast, r, fast_ewma) : r;
        slow_ewma = (slow_ewma > 0) ? wmix(w_slow, r, slow_ewma) : r;
        refresh_history_stats();
      end
      OP_PROG: begin
        if (!prog_valid) begin
          flight_ewma = 0; base_recv = 0; base_now = now;
          prog_valid = 1;
        end else if (now < last_now || rv < last_recv ||
                     (xp != 0 && xp != last_exp && rv == 0)) begin
          flight_ewma = 0; base_recv = 0; base_now = now;
          prog_rate = 0; prog_has = 0;
        end
        if (rv > base_recv && now > base_now) begin
          r = byte_rate(64'(rv - base_recv), now - base_now);
          flight_ewma = (flight_ewma > 0) ? wmix(w_prog, r, flight_ewma) : r;
          base_now = now;
          base_recv = rv;
          prog_rate = flight_ewma;
          prog_has = flight_ewma > 0;
        end
        last_now = now; last_recv = rv; last_exp = xp;
      end
      OP_CLR_EST: begin
        fast_ewma = 0; slow_ewma = 0; harm_mean = 0;
        prog_has = 0; prog_rate = 0;
      end
      default: clear_estimator();
    endcase
    if (fast_ewma > 0 && slow_ewma > 0) m = (fast_ewma < slow_ewma) ? fast_ewma : slow_ewma;
    else m = (fast_ewma > slow_ewma) ? fast_ewma : slow_ewma;
    if (m > 0) t = (harm_mean > 0) ? wmix(w_blend, harm_mean, m) : m;
    else t = harm_mean;
    if (prog_has) t = (t > 0 && t < prog_rate) ? t : prog_rate;
    e.thr = t[RATE_W-1:0];
    e.bps = (t > 0) ? t[BPS_W+4:5] : '1;
    e.med = med_ttfb;
    return e;
  endfunction

  // one report beat; valid stays high between back-to-back beats
  task automatic send_report(logic [1:0] op, logic [S_DATA_W-1:0] d);
    estimate_t e;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    e = predict_estimate(op, d);
    estimates_due = {estimates_due, e};
  endtask

  task automatic send_download(logic [31:0] ttfb, logic [31:0] total, logic [31:0] size);
    send_report(OP_DONE, {112'd0, size, total, ttfb});
  endtask

  task automatic send_progress(logic [47:0] now, logic [31:0] xp, logic [31:0] rv);
    send_report(OP_PROG, {rv, xp, now, 96'd0});
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= APB_AW'({idx, 2'b00}); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_FAST_W:  w_fast  = val[WGT_W-1:0];
      REG_SLOW_W:  w_slow  = val[WGT_W-1:0];
      REG_PROG_W:  w_prog  = val[WGT_W-1:0];
      REG_SPAN:    hspan   = val[SPAN_W-1:0];
      REG_BLEND_W: w_blend = val[WGT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (estimates_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_weights(int f, int s, int p, int span, int b);
    drain();
    write_reg(REG_FAST_W, f);
    write_reg(REG_SLOW_W, s);
    write_reg(REG_PROG_W, p);
    write_reg(REG_SPAN, span);
    write_reg(REG_BLEND_W, b);
  endtask

  task automatic test_directed();
    // zero payload time saturates the rate, zero size gives a zero rate
    send_download(0, 0, 32'hFFFF_FFFF);
    send_download(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_download(100, 50, 1000);
    send_download(0, 32'hFFFF_FFFF, 0);
    send_download(32'h1000, 32'h2000, 32'h0001_0000);
    send_report(OP_CLR_EST, '0);
    send_download(5, 32'h00F0_0000, 1);
    // first progress report restarts the context
    send_progress(48'd1000, 32'd50000, 32'd0);
    send_progress(48'd2000, 32'd50000, 32'd4000);
    send_progress(48'd2000, 32'd50000, 32'd8000);
    send_progress(48'd3000, 32'd50000, 32'd12000);
    send_progress(48'd2500, 32'd50000, 32'd13000);   // time goes back
    send_progress(48'd4000, 32'd50000, 32'd20000);
    send_progress(48'd5000, 32'd50000, 32'd1000);    // bytes go back
    send_progress(48'd6000, 32'd70000, 32'd0);       // new transfer
    send_progress(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_report(OP_CLR_EST, '0);
    send_progress(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_report(OP_CLR_ALL, '0);
    send_download(0, 0, 0);
    send_report(OP_CLR_ALL, '0);
    // wrap the history ring
    for (int i = 0; i < 26; i++)
      send_download($urandom_range(0, 500000), $urandom_range(0, 3000000), $urandom);
  endtask

  task automatic random_report();
    int sel;
    logic [S_DATA_W-1:0] d;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      if ($urandom_range(0, 3) == 0)
        send_download($urandom, $urandom, $urandom);
      else
        send_download($urandom_range(0, 2000000), $urandom_range(0, 20000000),
                      $urandom_range(0, 1 << $urandom_range(0, 31)));
    end else if (sel < 85) begin
      if ($urandom_range(0, 19) == 0) begin
        flow_exp = $urandom;
        flow_recv = 0;
      end else begin
        flow_recv += $urandom_range(0, 4000000);
      end
      flow_now += $urandom_range(0, 3) == 0 ? 48'd0 : 48'($urandom_range(1, 2000000));
      send_progress(flow_now, flow_exp, flow_recv);
    end else if (sel < 92) begin
      d = '0;
      for (int i = 0; i < S_DATA_W / 32; i++) d[i*32 +: 32] = $urandom;
      d[S_DATA_W-1 -: 16] = 16'($urandom);
      send_report(OP_PROG, d);
    end else if (sel < 97) begin
      send_report(OP_CLR_EST, S_DATA_W'({$urandom, $urandom}));
    end else begin
      send_report(OP_CLR_ALL, S_DATA_W'({$urandom, $urandom}));
    end
  endtask

  task automatic test_random_phase(int n, int src_pct, int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    flow_now = {16'd0, $urandom};
    flow_recv = 0;
    flow_exp = $urandom;
    for (int i = 0; i < n; i++) random_report();
  endtask

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    estimate_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (estimates_due.size() == 0) begin
        $error("result beat with no prediction pending");
        errors++;
      end else begin
        want = estimates_due.pop_front();
        if (m_tdata[39:0] !== want.thr) begin
          $error("throughput: expected %0h, got %0h", want.thr, m_tdata[39:0]);
          errors++;
        end
        if (m_tdata[75:40] !== want.bps) begin
          $error("bandwidth_bps: expected %0h, got %0h", want.bps, m_tdata[75:40]);
          errors++;
        end
        if (m_tdata[107:76] !== want.med) begin
          $error("median_ttfb_us: expected %0h, got %0h", want.med, m_tdata[107:76]);
          errors++;
        end
      end
    end
  end

  initial begin
    int waited;
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 0; s_tdata = '0; s_tuser = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    w_fast = 16'd32768; w_slow = 16'd6554; w_prog = 16'd19661;
    hspan = 5'd8; w_blend = 16'd39322;
    clear_estimator();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct = 7; snk_idle_pct = 68;
    test_directed();
    set_weights(0, 65535, 0, 1, 0);
    test_random_phase(540, 7, 68);
    set_weights(65535, 0, 65535, 24, 65535);
    test_random_phase(540, 68, 7);
    set_weights($urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(1, 24), $urandom_range(0, 65535));
    test_random_phase(530, 0, 0);

    s_tvalid <= 1'b0;
    waited = 0;
    while (estimates_due.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4000) @(posedge clk);
    if (errors == 0 && estimates_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
